[hw/rtl/yms_pkg.sv]
package yms_pkg;

  // Frame capacities
  localparam int MAX_DATA_LEN = 1024;
  localparam int SOH_LEN      = 128;
  localparam int LEN_W        = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ESTABLISHING,
    ST_ESTABLISHED,
    ST_TRANSFERRING,
    ST_FINISHING,
    ST_FINISHED,
    ST_ABORTED
  } stage_t;

  typedef enum logic [1:0] {
    W_C,
    W_ACK,
    W_CAN2
  } wait_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_RESEND,
    ERR_CAN
  } err_t;

  // Request types
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Frame actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_HEADER  = 3'd1;
  localparam logic [2:0] ACT_DATA    = 3'd2;
  localparam logic [2:0] ACT_RESEND  = 3'd3;
  localparam logic [2:0] ACT_EOT     = 3'd4;
  localparam logic [2:0] ACT_CAN     = 3'd5;
  localparam logic [2:0] ACT_END_HDR = 3'd6;

  // Events
  localparam logic [2:0] EVT_NONE      = 3'd0;
  localparam logic [2:0] EVT_FILE_INFO = 3'd1;
  localparam logic [2:0] EVT_DATA      = 3'd2;
  localparam logic [2:0] EVT_DONE      = 3'd3;
  localparam logic [2:0] EVT_SESS_END  = 3'd4;
  localparam logic [2:0] EVT_ERROR     = 3'd5;

  // Byte status
  localparam logic [1:0] BST_OK      = 2'd0;
  localparam logic [1:0] BST_GARBAGE = 2'd1;

  // Receiver reply bytes
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAME_1K    = 2'd0;
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       rx_byte;
    logic             next_file_present;
    logic [31:0]      next_file_size;
    logic [LEN_W-1:0] chunk_len;
  } yms_in_t;

  typedef struct packed {
    logic [2:0]       frame_action;
    logic [7:0]       frame_seq;
    logic             frame_is_1k;
    logic [LEN_W-1:0] valid_len;
    logic [2:0]       event_code;
    logic [15:0]      event_file_index;
    logic [1:0]       byte_status;
  } yms_out_t;

endpackage

[hw/rtl/yms_in_if.sv]
interface yms_in_if import yms_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [7:0]       rx_byte;
  logic             next_file_present;
  logic [31:0]      next_file_size;
  logic [LEN_W-1:0] chunk_len;

  modport source (output valid, req_type, rx_byte, next_file_present, next_file_size,
                  chunk_len, input ready);
  modport sink (input valid, req_type, rx_byte, next_file_present, next_file_size,
                chunk_len, output ready);
endinterface

[hw/rtl/yms_out_if.sv]
interface yms_out_if import yms_pkg::*;;
  logic             valid;
  logic             ready;
  logic [2:0]       frame_action;
  logic [7:0]       frame_seq;
  logic             frame_is_1k;
  logic [LEN_W-1:0] valid_len;
  logic [2:0]       event_code;
  logic [15:0]      event_file_index;
  logic [1:0]       byte_status;

  modport source (output valid, frame_action, frame_seq, frame_is_1k, valid_len,
                  event_code, event_file_index, byte_status, input ready);
  modport sink (input valid, frame_action, frame_seq, frame_is_1k, valid_len,
                event_code, event_file_index, byte_status, output ready);
endinterface

[hw/rtl/yms_cfg_if.sv]
interface yms_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/ymodem_sender_control.sv]
// Channel | Dir | Transfer moves                      | Handshake
// --------+-----+-------------------------------------+--------------
// in_ch   | in  | start / reply byte / ms tick + file | valid, ready
// out_ch  | out | frame command, event, byte status   | valid, ready
// cfg_ch  | in  | register index + write data         | valid, ready
//
// One item per cycle sustained while out_ch takes each result: an item is held in the input
// register, is stepped through the control logic (saturating adds and compares) and
// lands in the result register.
// Reset (rst_n low, synchronous) clears the control state and holds both ready outputs low.
// A stall on out_ch holds the result; the input register still takes one more
// transfer, after which in_ch.ready drops until the result is taken.
module ymodem_sender_control import yms_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  yms_in_if.sink     in_ch,
  yms_out_if.source  out_ch,
  yms_cfg_if.sink    cfg_ch
);

  // Configuration registers
  logic        k1_r;
  logic [3:0]  rlim_r;
  logic [15:0] tmo_r;

  // Pipeline registers
  logic     in_valid_r, in_valid_nxt;
  yms_in_t  in_r;
  logic     out_valid_r, out_valid_nxt;
  yms_out_t out_r;
  yms_out_t res;

  // Control state
  stage_t      stage_r, stage_nxt;
  wait_t       wait_r, wait_nxt;
  logic [4:0]  retry_r, retry_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [31:0] sent_r, sent_nxt;
  logic [31:0] fsize_r, fsize_nxt;
  logic [15:0] fnum_r, fnum_nxt;
  logic        held_r, held_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  // Step helpers
  logic             accept, adv, in_ready;
  logic             do_proc;
  err_t             err, err_eff;
  logic [LEN_W-1:0] cap, dlen;
  logic [32:0]      sent_sum;
  logic [15:0]      ticks_inc;
  logic [4:0]       retry_inc;

  // Advance the item once the result register is free or being emptied
  assign adv      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = rst_n && (!in_valid_r || adv);
  assign accept   = in_ch.valid && in_ready;

  assign in_ch.ready = in_ready;
  assign cfg_ch.ready = rst_n;

  assign in_valid_nxt  = accept ? 1'b1 : (adv ? 1'b0 : in_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  assign out_ch.valid            = out_valid_r;
  assign out_ch.frame_action     = out_r.frame_action;
  assign out_ch.frame_seq        = out_r.frame_seq;
  assign out_ch.frame_is_1k      = out_r.frame_is_1k;
  assign out_ch.valid_len        = out_r.valid_len;
  assign out_ch.event_code       = out_r.event_code;
  assign out_ch.event_file_index = out_r.event_file_index;
  assign out_ch.byte_status      = out_r.byte_status;

  // Data frame length: zero or oversized chunk means a full frame
  assign cap  = k1_r ? LEN_W'(MAX_DATA_LEN) : LEN_W'(SOH_LEN);
  assign dlen = (in_r.chunk_len == '0 || in_r.chunk_len > cap) ? cap : in_r.chunk_len;
  assign sent_sum  = {1'b0, sent_r} + 33'(dlen);
  assign ticks_inc = (ticks_r == 16'hFFFF) ? ticks_r : ticks_r + 16'd1;
  assign retry_inc = (retry_r == 5'd31) ? retry_r : retry_r + 5'd1;

  always_comb begin
    stage_nxt = stage_r;
    wait_nxt  = wait_r;
    retry_nxt = retry_r;
    seq_nxt   = seq_r;
    sent_nxt  = sent_r;
    fsize_nxt = fsize_r;
    fnum_nxt  = fnum_r;
    held_nxt  = held_r;
    ticks_nxt = ticks_r;
    res       = '0;
    do_proc   = 1'b0;
    err       = ERR_NONE;
    err_eff   = ERR_NONE;

    // Decode the request into a process call
    case (in_r.req_type)
      REQ_START: begin
        stage_nxt = ST_ESTABLISHING;
      end
      REQ_BYTE: begin
        if (in_r.rx_byte == B_CAN) begin
          // A CAN with the sub-wait armed cancels; otherwise a CAN only arms the sub-wait
          if (wait_r == W_CAN2) begin
            do_proc = 1'b1;
            err     = ERR_CAN;
          end else begin
            wait_nxt = W_CAN2;
          end
        end else begin
          unique case (stage_r) inside
            ST_ESTABLISHING, ST_ABORTED: begin
              if (in_r.rx_byte == B_C) begin
                do_proc = 1'b1;
              end else begin
                res.byte_status = BST_GARBAGE;
              end
            end
            ST_ESTABLISHED: begin
              if (in_r.rx_byte == B_NAK) begin
                do_proc = 1'b1;
                err     = ERR_RESEND;
              end else if (in_r.rx_byte == B_ACK || in_r.rx_byte == B_C) begin
                // Header needs ACK followed by C before data starts
                if (wait_r == W_ACK) begin
                  if (in_r.rx_byte == B_ACK) wait_nxt = W_C;
                end else if (wait_r == W_C) begin
                  if (in_r.rx_byte == B_C) do_proc = 1'b1;
                  else wait_nxt = W_ACK;
                end else begin
                  wait_nxt = W_ACK;
                end
              end else begin
                res.byte_status = BST_GARBAGE;
              end
            end
            ST_TRANSFERRING, ST_FINISHED: begin
              if (in_r.rx_byte == B_ACK) begin
                do_proc = 1'b1;
              end else if (in_r.rx_byte == B_NAK) begin
                do_proc = 1'b1;
                err     = ERR_RESEND;
              end else begin
                res.byte_status = BST_GARBAGE;
              end
            end
            ST_FINISHING: begin
              // First EOT must be NAKed; anything else resends it
              do_proc = 1'b1;
              err     = (in_r.rx_byte == B_NAK) ? ERR_NONE : ERR_RESEND;
            end
            default: begin
              res.byte_status = BST_GARBAGE;
            end
          endcase
        end
      end
      REQ_TICK: begin
        ticks_nxt = ticks_inc;
        if (stage_r != ST_IDLE && ticks_inc >= tmo_r) begin
          ticks_nxt = '0;
          do_proc   = 1'b1;
          err       = ERR_RESEND;
        end
      end
      default: ;
    endcase

    if (do_proc) begin
      err_eff = err;
      if (err == ERR_CAN) begin
        res.frame_action     = ACT_CAN;
        held_nxt             = 1'b1;
        ticks_nxt            = '0;
        stage_nxt            = ST_ABORTED;
        res.event_code       = EVT_ERROR;
        res.event_file_index = fnum_r;
      end else if (err == ERR_RESEND) begin
        retry_nxt = retry_inc;
        if (retry_inc > {1'b0, rlim_r}) begin
          // Retry budget spent: cancel the session
          res.frame_action     = ACT_CAN;
          held_nxt             = 1'b1;
          ticks_nxt            = '0;
          res.event_code       = EVT_ERROR;
          res.event_file_index = fnum_r;
          err_eff              = ERR_CAN;
          stage_nxt            = ST_ABORTED;
        end else if (held_r) begin
          res.frame_action = ACT_RESEND;
          ticks_nxt        = '0;
        end
      end else begin
        unique case (stage_r) inside
          ST_ESTABLISHING: begin
            seq_nxt  = '0;
            sent_nxt = '0;
            if (in_r.next_file_present) begin
              fsize_nxt            = in_r.next_file_size;
              res.event_code       = EVT_FILE_INFO;
              res.event_file_index = fnum_r;
              res.frame_action     = ACT_HEADER;
              res.frame_seq        = seq_nxt;
              res.valid_len        = LEN_W'(SOH_LEN);
              seq_nxt              = seq_nxt + 8'd1;
              stage_nxt            = ST_ESTABLISHED;
            end else begin
              res.frame_action     = ACT_END_HDR;
              res.event_code       = EVT_SESS_END;
              res.event_file_index = fnum_r;
              stage_nxt            = ST_IDLE;
            end
            held_nxt  = 1'b1;
            ticks_nxt = '0;
          end
          ST_ESTABLISHED, ST_TRANSFERRING: begin
            held_nxt  = 1'b1;
            ticks_nxt = '0;
            if ((stage_r == ST_ESTABLISHED && fsize_r == '0) ||
                (stage_r == ST_TRANSFERRING && sent_r >= fsize_r)) begin
              res.frame_action = ACT_EOT;
              wait_nxt         = W_ACK;
              stage_nxt        = ST_FINISHING;
            end else begin
              res.event_code       = EVT_DATA;
              res.event_file_index = fnum_r;
              res.frame_action     = ACT_DATA;
              res.frame_seq        = seq_nxt;
              res.frame_is_1k      = k1_r;
              res.valid_len        = dlen;
              seq_nxt              = seq_nxt + 8'd1;
              sent_nxt             = sent_sum[32] ? 32'hFFFF_FFFF : sent_sum[31:0];
              stage_nxt            = ST_TRANSFERRING;
            end
          end
          ST_FINISHING: begin
            res.frame_action = ACT_EOT;
            held_nxt         = 1'b1;
            ticks_nxt        = '0;
            stage_nxt        = ST_FINISHED;
          end
          ST_FINISHED: begin
            res.event_code       = EVT_DONE;
            res.event_file_index = fnum_r;
            fnum_nxt             = fnum_r + 16'd1;
            stage_nxt            = ST_ESTABLISHING;
          end
          ST_ABORTED: begin
            if (in_r.next_file_present) begin
              fsize_nxt            = in_r.next_file_size;
              res.event_code       = EVT_FILE_INFO;
              res.event_file_index = fnum_r;
              res.frame_action     = ACT_HEADER;
              res.frame_seq        = seq_nxt;
              res.valid_len        = LEN_W'(SOH_LEN);
              seq_nxt              = seq_nxt + 8'd1;
              held_nxt             = 1'b1;
              ticks_nxt            = '0;
              stage_nxt            = (in_r.next_file_size != '0) ? ST_TRANSFERRING
                                                                 : ST_FINISHING;
            end else begin
              stage_nxt            = ST_IDLE;
              res.event_code       = EVT_ERROR;
              res.event_file_index = fnum_r;
            end
          end
          default: ;
        endcase
      end

      if (err_eff == ERR_NONE) retry_nxt = '0;
      // Drop the session counters on cancel; retry count survives
      if (err_eff == ERR_CAN) begin
        seq_nxt   = '0;
        sent_nxt  = '0;
        fsize_nxt = '0;
        fnum_nxt  = '0;
      end
      if (stage_nxt != ST_FINISHING) wait_nxt = W_ACK;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r   <= 1'b0;
      rlim_r <= 4'd10;
      tmo_r  <= 16'd1000;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_FRAME_1K:    k1_r   <= cfg_ch.data[0];
        CFG_RETRY_LIMIT: rlim_r <= cfg_ch.data[3:0];
        CFG_TIMEOUT:     tmo_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Handshake control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r.req_type          <= in_ch.req_type;
      in_r.rx_byte           <= in_ch.rx_byte;
      in_r.next_file_present <= in_ch.next_file_present;
      in_r.next_file_size    <= in_ch.next_file_size;
      in_r.chunk_len         <= in_ch.chunk_len;
    end
    if (adv) out_r <= res;
  end

  // Control state advances with each item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_IDLE;
      wait_r  <= W_C;
      retry_r <= '0;
      seq_r   <= '0;
      sent_r  <= '0;
      fsize_r <= '0;
      fnum_r  <= '0;
      held_r  <= 1'b0;
      ticks_r <= '0;
    end else if (adv) begin
      stage_r <= stage_nxt;
      wait_r  <= wait_nxt;
      retry_r <= retry_nxt;
      seq_r   <= seq_nxt;
      sent_r  <= sent_nxt;
      fsize_r <= fsize_nxt;
      fnum_r  <= fnum_nxt;
      held_r  <= held_nxt;
      ticks_r <= ticks_nxt;
    end
  end

endmodule

[hw/rtl/yms_checker.sv]
module yms_checker import yms_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       frame_action,
  input logic [LEN_W-1:0] valid_len
);

  // No result in the cycle after reset
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A fresh result needs an earlier input transfer through the input register
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without input transfer");

  // Empty result register means the input side is open
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frame_action) && $stable(valid_len))
    else $error("stalled result changed");

endmodule

bind ymodem_sender_control yms_checker u_yms_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .frame_action (out_ch.frame_action),
  .valid_len    (out_ch.valid_len)
);

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import yms_pkg::*;

  // The request type that the block must ignore
  localparam logic [1:0]  REQ_UNUSED    = 2'd3;
  // One file large enough to carry the sequence number past 255
  localparam logic [31:0] BIG_FILE_SIZE = 32'd40000;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          HOLD_OFF      = 300;
  localparam int          SETTLE_CYCLES = 8;

  // Mirror of the control machine: tracks stage, counters and registers,
  // and keeps the frame commands still owed by the block, oldest first.
  class sender_mirror;
    bit        use_1k;
    bit [3:0]  retry_limit;
    bit [15:0] timeout_ticks;
    stage_t    stage;
    wait_t     reply_wait;
    bit [4:0]  retry_count;
    bit [7:0]  seq_number;
    bit [31:0] bytes_sent;
    bit [31:0] announced_size;
    bit [15:0] file_number;
    bit        frame_held;
    bit [15:0] idle_ticks;
    yms_in_t   req;
    yms_out_t  cmd;
    yms_out_t  pending_cmds[$];
    int        mismatches;

    function new();
      use_1k         = 1'b0;
      retry_limit    = 4'd10;
      timeout_ticks  = 16'd1000;
      stage          = ST_IDLE;
      reply_wait     = W_C;
      retry_count    = '0;
      seq_number     = '0;
      bytes_sent     = '0;
      announced_size = '0;
      file_number    = '0;
      frame_held     = 1'b0;
      idle_ticks     = '0;
      mismatches     = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] value);
      case (idx)
        CFG_FRAME_1K:    use_1k = value[0];
        CFG_RETRY_LIMIT: retry_limit = value[3:0];
        CFG_TIMEOUT:     timeout_ticks = value;
        default: ;
      endcase
    endfunction

    function void emit_event(logic [2:0] code);
      cmd.event_code       = code;
      cmd.event_file_index = file_number;
    endfunction

    function void send_frame(logic [2:0] action);
      cmd.frame_action = action;
      frame_held       = 1'b1;
      idle_ticks       = '0;
    endfunction

    function void send_data();
      bit [LEN_W-1:0] cap;
      bit [LEN_W-1:0] len;
      bit [32:0]      sum;
      cap = use_1k ? LEN_W'(MAX_DATA_LEN) : LEN_W'(SOH_LEN);
      len = req.chunk_len;
      if (len == 0 || len > cap) len = cap;
      emit_event(EVT_DATA);
      send_frame(ACT_DATA);
      cmd.frame_seq   = seq_number;
      cmd.frame_is_1k = use_1k;
      cmd.valid_len   = len;
      seq_number++;
      sum = {1'b0, bytes_sent} + 33'(len);
      bytes_sent = sum[32] ? '1 : sum[31:0];
    endfunction

    function void send_header();
      announced_size = req.next_file_size;
      emit_event(EVT_FILE_INFO);
      send_frame(ACT_HEADER);
      cmd.frame_seq = seq_number;
      cmd.valid_len = LEN_W'(SOH_LEN);
      seq_number++;
    endfunction

    function void advance_stage();
      case (stage)
        ST_ESTABLISHING: begin
          seq_number = '0;
          bytes_sent = '0;
          if (req.next_file_present) begin
            send_header();
            stage = ST_ESTABLISHED;
          end else begin
            send_frame(ACT_END_HDR);
            emit_event(EVT_SESS_END);
            stage = ST_IDLE;
          end
        end
        ST_ESTABLISHED: begin
          if (announced_size == 0) begin
            send_frame(ACT_EOT);
            reply_wait = W_ACK;
            stage = ST_FINISHING;
          end else begin
            send_data();
            stage = ST_TRANSFERRING;
          end
        end
        ST_TRANSFERRING: begin
          if (bytes_sent >= announced_size) begin
            send_frame(ACT_EOT);
            reply_wait = W_ACK;
            stage = ST_FINISHING;
          end else begin
            send_data();
          end
        end
        ST_FINISHING: begin
          send_frame(ACT_EOT);
          stage = ST_FINISHED;
        end
        ST_FINISHED: begin
          emit_event(EVT_DONE);
          file_number++;
          stage = ST_ESTABLISHING;
        end
        ST_ABORTED: begin
          if (req.next_file_present) begin
            send_header();
            stage = (announced_size != 0) ? ST_TRANSFERRING : ST_FINISHING;
          end else begin
            stage = ST_IDLE;
            emit_event(EVT_ERROR);
          end
        end
        default: ;
      endcase
    endfunction

    // Resolve one outcome: move on, retry the last frame, or cancel
    function void settle(err_t err);
      if (err == ERR_CAN) begin
        send_frame(ACT_CAN);
        stage = ST_ABORTED;
        emit_event(EVT_ERROR);
      end else if (err == ERR_NONE) begin
        advance_stage();
      end else begin
        if (retry_count < 5'd31) retry_count++;
        if (retry_count > retry_limit) begin
          send_frame(ACT_CAN);
          emit_event(EVT_ERROR);
          err = ERR_CAN;
          stage = ST_ABORTED;
        end else if (frame_held) begin
          send_frame(ACT_RESEND);
        end
      end
      if (err == ERR_NONE) retry_count = '0;
      if (err == ERR_CAN) begin
        seq_number     = '0;
        bytes_sent     = '0;
        announced_size = '0;
        file_number    = '0;
      end
      if (stage != ST_FINISHING) reply_wait = W_ACK;
    endfunction

    function logic [1:0] take_reply(logic [7:0] b);
      if (b == B_CAN) begin
        if (reply_wait == W_CAN2) settle(ERR_CAN);
        else reply_wait = W_CAN2;
        return BST_OK;
      end
      case (stage)
        ST_ESTABLISHING, ST_ABORTED: begin
          if (b == B_C) begin
            settle(ERR_NONE);
            return BST_OK;
          end
        end
        ST_ESTABLISHED: begin
          if (b == B_NAK) begin
            settle(ERR_RESEND);
            return BST_OK;
          end
          if (b == B_ACK || b == B_C) begin
            if (reply_wait == W_ACK) begin
              if (b == B_ACK) reply_wait = W_C;
            end else if (reply_wait == W_C) begin
              if (b == B_C) settle(ERR_NONE);
              else reply_wait = W_ACK;
            end else begin
              reply_wait = W_ACK;
            end
            return BST_OK;
          end
        end
        ST_TRANSFERRING, ST_FINISHED: begin
          if (b == B_ACK) begin
            settle(ERR_NONE);
            return BST_OK;
          end
          if (b == B_NAK) begin
            settle(ERR_RESEND);
            return BST_OK;
          end
        end
        ST_FINISHING: begin
          settle((b == B_NAK) ? ERR_NONE : ERR_RESEND);
          return BST_OK;
        end
        default: ;
      endcase
      return BST_GARBAGE;
    endfunction

    function void note_request(yms_in_t it);
      req = it;
      cmd = '0;
      case (it.req_type)
        REQ_START: stage = ST_ESTABLISHING;
        REQ_BYTE:  cmd.byte_status = take_reply(it.rx_byte);
        REQ_TICK: begin
          if (idle_ticks != 16'hFFFF) idle_ticks++;
          if (stage != ST_IDLE && idle_ticks >= timeout_ticks) begin
            idle_ticks = '0;
            settle(ERR_RESEND);
          end
        end
        default: ;
      endcase
      pending_cmds.push_back(cmd);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_command(yms_out_t got);
      yms_out_t want;
      if (pending_cmds.size() == 0) begin
        $error("frame command %p arrived with none pending", got);
        mismatches++;
        return;
      end
      want = pending_cmds.pop_front();
      compare_field("frame_action", 32'(want.frame_action), 32'(got.frame_action));
      compare_field("frame_seq", 32'(want.frame_seq), 32'(got.frame_seq));
      compare_field("frame_is_1k", 32'(want.frame_is_1k), 32'(got.frame_is_1k));
      compare_field("valid_len", 32'(want.valid_len), 32'(got.valid_len));
      compare_field("event_code", 32'(want.event_code), 32'(got.event_code));
      compare_field("event_file_index", 32'(want.event_file_index),
                    32'(got.event_file_index));
      compare_field("byte_status", 32'(want.byte_status), 32'(got.byte_status));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  yms_in_if  in_ch();
  yms_out_if out_ch();
  yms_cfg_if cfg_ch();

  ymodem_sender_control i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sender_mirror mirror = new();

  // Knobs shared between the stimulus, the receiver and the watchdog
  bit sender_calm;
  bit sink_calm;
  bit hold_off_due;
  bit big_file_due;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample every channel at the rising edge. Note the request before checking
  // the command, although a command never stems from a request taken at the same edge.
  always @(posedge clk) begin
    yms_in_t  seen_req;
    yms_out_t seen_cmd;
    bit       moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen_req.req_type          = in_ch.req_type;
        seen_req.rx_byte           = in_ch.rx_byte;
        seen_req.next_file_present = in_ch.next_file_present;
        seen_req.next_file_size    = in_ch.next_file_size;
        seen_req.chunk_len         = in_ch.chunk_len;
        mirror.note_request(seen_req);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_cmd.frame_action     = out_ch.frame_action;
        seen_cmd.frame_seq        = out_ch.frame_seq;
        seen_cmd.frame_is_1k      = out_ch.frame_is_1k;
        seen_cmd.valid_len        = out_ch.valid_len;
        seen_cmd.event_code       = out_ch.event_code;
        seen_cmd.event_file_index = out_ch.event_file_index;
        seen_cmd.byte_status      = out_ch.byte_status;
        mirror.check_command(seen_cmd);
        moved = 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        mirror.set_register(cfg_ch.index, cfg_ch.data);
        moved = 1'b1;
      end
    end
    // Count cycles in which no transfer happens on any channel
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  // Give up once the block has gone quiet for far longer than any stall
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // Receiver: stall at random, take everything in calm stretches, and hold off
  // once for a long stretch so that the block backs up into its input
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end else begin
        out_ch.ready <= sink_calm || ($urandom_range(99) >= 24);
      end
    end
  end

  function automatic yms_in_t request_of(logic [1:0] kind, logic [7:0] b, logic present,
                                         logic [31:0] size, logic [LEN_W-1:0] chunk);
    yms_in_t it;
    it.req_type          = kind;
    it.rx_byte           = b;
    it.next_file_present = present;
    it.next_file_size    = size;
    it.chunk_len         = chunk;
    return it;
  endfunction

  // Pick the next request from the mirrored stage: mostly the reply a
  // well-behaved receiver would give, with ticks, cancels and noise mixed in.
  // Keep the big file clear of noise and cancels so it runs to the wrap.
  function automatic yms_in_t pick_request();
    yms_in_t it;
    int      roll;
    bit      big_run;
    big_run = (mirror.announced_size == BIG_FILE_SIZE);
    roll = $urandom_range(99);
    it.req_type          = REQ_BYTE;
    it.rx_byte           = 8'($urandom);
    it.next_file_present = ($urandom_range(99) < 85);
    it.next_file_size    = ($urandom_range(9) < 2) ? 32'd0 : 32'($urandom_range(1500, 1));
    it.chunk_len         = ($urandom_range(1) == 0) ? '0 : LEN_W'($urandom_range(1100, 1));
    if (!big_run && roll < 8) begin
      it.req_type  = 2'($urandom);
      it.chunk_len = LEN_W'($urandom);
      if ($urandom_range(3) == 0) it.next_file_size = $urandom;
    end else if (roll < 18) begin
      it.req_type = REQ_TICK;
    end else if (!big_run && (roll < 21 || (mirror.reply_wait == W_CAN2 && roll < 50))) begin
      it.rx_byte = B_CAN;
    end else begin
      case (mirror.stage)
        ST_IDLE: it.req_type = REQ_START;
        ST_ESTABLISHING, ST_ABORTED: begin
          it.rx_byte = B_C;
          if (big_file_due && mirror.stage == ST_ESTABLISHING) begin
            big_file_due         = 1'b0;
            it.next_file_present = 1'b1;
            it.next_file_size    = BIG_FILE_SIZE;
          end
        end
        ST_ESTABLISHED: begin
          if ($urandom_range(9) == 0) it.rx_byte = B_NAK;
          else it.rx_byte = (mirror.reply_wait == W_C) ? B_C : B_ACK;
        end
        ST_TRANSFERRING, ST_FINISHED: it.rx_byte = ($urandom_range(9) == 0) ? B_NAK : B_ACK;
        ST_FINISHING: it.rx_byte = ($urandom_range(99) < 85) ? B_NAK : B_ACK;
        default: it.req_type = REQ_START;
      endcase
    end
    return it;
  endfunction

  // Offer one request and hold it until the transfer. Entered and left at a
  // falling edge; valid stays high on exit so back-to-back requests need no
  // second assignment in the same step.
  task automatic offer_request(input yms_in_t it);
    while (!sender_calm && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.req_type          <= it.req_type;
    in_ch.rx_byte           <= it.rx_byte;
    in_ch.next_file_present <= it.next_file_present;
    in_ch.next_file_size    <= it.next_file_size;
    in_ch.chunk_len         <= it.chunk_len;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic program_register(input logic [1:0] idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed command, then let the pipeline settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (mirror.pending_cmds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    bit          ph_1k;
    logic [3:0]  ph_retry;
    logic [15:0] ph_timeout;
    int          ph_items;

    rst_n                   = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.req_type          = REQ_START;
    in_ch.rx_byte           = '0;
    in_ch.next_file_present = 1'b0;
    in_ch.next_file_size    = '0;
    in_ch.chunk_len         = '0;
    out_ch.ready            = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = CFG_FRAME_1K;
    cfg_ch.data             = '0;
    sender_calm             = 1'b0;
    sink_calm               = 1'b0;
    hold_off_due            = 1'b0;
    big_file_due            = 1'b0;
    quiet_cycles            = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass: 1k frames, tight retry budget, timeout on every tick
    program_register(CFG_FRAME_1K, 16'd1);
    program_register(CFG_RETRY_LIMIT, 16'd2);
    program_register(CFG_TIMEOUT, 16'd1);

    // Unused request type with every field at its top: must be ignored
    offer_request(request_of(REQ_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF, 11'h7FF));
    // Tick while idle counts but never times out
    offer_request(request_of(REQ_TICK, 8'h00, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_START, 8'h00, 1'b0, 32'd0, '0));
    // Timeout with no frame sent yet: retry counted, nothing resent
    offer_request(request_of(REQ_TICK, 8'h00, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_BYTE, 8'hFF, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_BYTE, B_C, 1'b1, 32'hFFFF_FFFF, '0));
    offer_request(request_of(REQ_BYTE, B_NAK, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_BYTE, B_ACK, 1'b0, 32'd0, '0));
    // Oversized chunk falls back to a full frame
    offer_request(request_of(REQ_BYTE, B_C, 1'b0, 32'd0, 11'h7FF));
    offer_request(request_of(REQ_BYTE, B_ACK, 1'b0, 32'd0, 11'd1));
    offer_request(request_of(REQ_BYTE, B_ACK, 1'b0, 32'd0, 11'd1024));
    // Double cancel aborts and clears the counters
    offer_request(request_of(REQ_BYTE, B_CAN, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_BYTE, B_CAN, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_BYTE, B_C, 1'b0, 32'd0, '0));
    // Empty file straight to EOT, a resend, then the closing handshake
    offer_request(request_of(REQ_START, 8'h00, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_BYTE, B_C, 1'b1, 32'd0, '0));
    offer_request(request_of(REQ_BYTE, B_ACK, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_BYTE, B_C, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_BYTE, B_ACK, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_BYTE, B_NAK, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_BYTE, B_ACK, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_BYTE, B_C, 1'b0, 32'd0, '0));
    // Repeated timeouts run past the retry limit and cancel
    offer_request(request_of(REQ_START, 8'h00, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_TICK, 8'h00, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_TICK, 8'h00, 1'b0, 32'd0, '0));
    offer_request(request_of(REQ_TICK, 8'h00, 1'b0, 32'd0, '0));
    drain_results();

    // Random phases, each under its own register setting
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin ph_1k = 1'b0; ph_retry = 4'd10; ph_timeout = 16'hFFFF; ph_items = 120; end
        1: begin ph_1k = 1'b1; ph_retry = 4'd0;  ph_timeout = 16'd3;    ph_items = 110; end
        2: begin ph_1k = 1'b0; ph_retry = 4'd15; ph_timeout = 16'd5;    ph_items = 400; end
        3: begin ph_1k = 1'b1; ph_retry = 4'd4;  ph_timeout = 16'd1;    ph_items = 110; end
        default: begin
          ph_1k = 1'b0; ph_retry = 4'd7; ph_timeout = 16'd12; ph_items = 110;
        end
      endcase
      program_register(CFG_FRAME_1K, {15'd0, ph_1k});
      program_register(CFG_RETRY_LIMIT, {12'd0, ph_retry});
      program_register(CFG_TIMEOUT, ph_timeout);
      // Second phase runs with no idling on either side; third one carries
      // the big file and the long receiver hold-off
      sender_calm  = (p == 1);
      sink_calm    = (p == 1);
      hold_off_due = (p == 2);
      big_file_due = (p == 2);
      repeat (ph_items) offer_request(pick_request());
      drain_results();
    end

    if (mirror.pending_cmds.size() != 0) begin
      $error("%0d frame commands never arrived", mirror.pending_cmds.size());
      mirror.mismatches++;
    end
    if (mirror.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
